// ===== design/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
`default_nettype none
package fbpa_pkg;

    localparam int CAPACITY  = 256;
    localparam int ADDR_W    = 32;
    localparam int BSIZE_W   = 17;
    localparam int CFG_IDX_W = 1;
    localparam int TOTAL_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(64);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NULL    = 3'd2,
        ST_INVALID = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               done;
        logic [ADDR_W-1:0]  quot;
        logic [BSIZE_W-1:0] rem;
    } t_div_res;

    typedef struct packed {
        logic pop;
        logic push;
    } t_stk_op;

endpackage
`default_nettype wire

// ===== design/fbpa_req_if.sv =====
// Request channel: action and address beats into the allocator.
`default_nettype none
interface fbpa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [fbpa_pkg::ADDR_W-1:0] address;

    modport source (output valid, output action, output address, input ready);
    modport sink (input valid, input action, input address, output ready);
endinterface
`default_nettype wire

// ===== design/fbpa_rsp_if.sv =====
// Response channel: status, block address and counters out of the allocator.
`default_nettype none
interface fbpa_rsp_if #(
    parameter int CAPACITY = fbpa_pkg::CAPACITY
);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                         valid;
    logic                         ready;
    fbpa_pkg::t_status            status;
    logic [fbpa_pkg::ADDR_W-1:0]  block_address;
    logic [CNT_W-1:0]             in_use;
    logic [CNT_W-1:0]             highest_in_use;
    logic [fbpa_pkg::TOTAL_W-1:0] total_allocated;
    logic [fbpa_pkg::TOTAL_W-1:0] total_freed;

    modport source (output valid, output status, output block_address, output in_use,
                    output highest_in_use, output total_allocated, output total_freed,
                    input ready);
    modport sink (input valid, input status, input block_address, input in_use,
                  input highest_in_use, input total_allocated, input total_freed,
                  output ready);
endinterface
`default_nettype wire

// ===== design/fbpa_div.sv =====
// Restoring divider, one quotient bit per cycle, for block offset over block size.
`default_nettype none
module fbpa_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [fbpa_pkg::ADDR_W-1:0]   i_dividend,
    input  wire logic [fbpa_pkg::BSIZE_W-1:0]  i_divisor,
    output fbpa_pkg::t_div_res                 o_res
);
    localparam int DVD_W = fbpa_pkg::ADDR_W;
    localparam int DVS_W = fbpa_pkg::BSIZE_W;
    localparam int STP_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [STP_W-1:0] r_step;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_fits;

    assign w_trial = {r_rem, r_q[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_fits  = ~w_diff[DVS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_q;
    assign o_res.rem  = r_rem;

endmodule
`default_nettype wire

// ===== design/fbpa_stack.sv =====
// Free-index stack in a synchronous memory; entries never pushed read as their own position.
`default_nettype none
module fbpa_stack #(
    parameter int CAPACITY = fbpa_pkg::CAPACITY
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire fbpa_pkg::t_stk_op                          i_op,
    input  wire logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] i_push_data,
    output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0]      o_top,
    output logic [$clog2(CAPACITY + 1)-1:0]                 o_count
);
    localparam int IDX_W = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [IDX_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_low;
    logic [IDX_W-1:0] r_mem_q;
    logic [IDX_W-1:0] r_pos;
    logic             r_dflt;

    logic [CNT_W-1:0] w_pos;

    assign w_pos = r_count - 1'b1;

    // r_low is the lowest depth ever reached; positions below it were never pushed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(CAPACITY);
            r_low   <= CNT_W'(CAPACITY);
        end else if (i_op.pop) begin
            r_count <= w_pos;
            if (w_pos < r_low) begin
                r_low <= w_pos;
            end
        end else if (i_op.push) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            mem[r_count[IDX_W-1:0]] <= i_push_data;
        end
        if (i_op.pop) begin
            r_mem_q <= mem[w_pos[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.pop) begin
            r_pos  <= w_pos[IDX_W-1:0];
            r_dflt <= w_pos < r_low;
        end
    end

    assign o_top   = r_dflt ? r_pos : r_mem_q;
    assign o_count = r_count;

endmodule
`default_nettype wire

// ===== design/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: control, counters and response register.
//
// Hands out and takes back equal-size blocks of a pool of CAPACITY blocks that starts at
// base_address. Free block indices sit on a LIFO stack in a one-port synchronous memory,
// ascending after reset, so the first allocate returns the highest block; no clearing pass
// is needed after reset. One request beat is worked on at a time. An allocate passes
// through memory read, multiply, add and response load. A free of an address at or above
// base_address runs the 32-step restoring divider that finds the block index and checks
// alignment; a null free, a free below the pool and a failed allocate go straight to the
// response load. The response sits in an output register, and a new request is accepted
// while it waits to be taken. Configuration writes must be made while no request is in
// flight.
`default_nettype none
module fixed_block_pool_allocator #(
    parameter int CAPACITY = fbpa_pkg::CAPACITY
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fbpa_pkg::ADDR_W-1:0]      i_cfg_data,
    fbpa_req_if.sink                              i_req,
    fbpa_rsp_if.source                            o_rsp
);
    localparam int IDX_W   = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = fbpa_pkg::ADDR_W;
    localparam int BSIZE_W = fbpa_pkg::BSIZE_W;
    localparam int TOTAL_W = fbpa_pkg::TOTAL_W;
    localparam int PROD_W  = IDX_W + BSIZE_W;

    fbpa_pkg::t_state  r_state;
    fbpa_pkg::t_state  n_state;

    logic [ADDR_W-1:0]  r_base;
    logic [BSIZE_W-1:0] r_bsize;
    logic [CNT_W-1:0]   r_in_use;
    logic [CNT_W-1:0]   r_high;
    logic [TOTAL_W-1:0] r_alloc_tot;
    logic [TOTAL_W-1:0] r_free_tot;
    logic [PROD_W-1:0]  r_prod;
    logic [ADDR_W-1:0]  r_res_addr;
    fbpa_pkg::t_status  r_status;

    logic               r_rsp_valid;
    fbpa_pkg::t_status  r_rsp_status;
    logic [ADDR_W-1:0]  r_rsp_addr;
    logic [CNT_W-1:0]   r_rsp_in_use;
    logic [CNT_W-1:0]   r_rsp_high;
    logic [TOTAL_W-1:0] r_rsp_alloc;
    logic [TOTAL_W-1:0] r_rsp_free;

    logic               w_ready;
    logic               w_acc;
    logic               w_div_start;
    logic               w_div_ok;
    logic               w_load;
    logic [BSIZE_W-1:0] w_bs_eff;
    logic [CNT_W-1:0]   w_in_use_inc;
    fbpa_pkg::t_stk_op  w_stk_op;
    fbpa_pkg::t_div_res w_div;
    logic [IDX_W-1:0]   w_top;
    logic [CNT_W-1:0]   w_count;

    assign w_bs_eff     = (r_bsize == '0) ? BSIZE_W'(1) : r_bsize;
    assign w_ready      = (r_state == fbpa_pkg::S_IDLE);
    assign w_acc        = i_req.valid & w_ready;
    assign w_in_use_inc = r_in_use + 1'b1;
    assign w_div_ok     = (w_div.rem == '0) && (w_div.quot < ADDR_W'(CAPACITY));

    fbpa_stack #(
        .CAPACITY (CAPACITY)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_stk_op),
        .i_push_data (w_div.quot[IDX_W-1:0]),
        .o_top       (w_top),
        .o_count     (w_count)
    );

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_req.address - r_base),
        .i_divisor  (w_bs_eff),
        .o_res      (w_div)
    );

    always_comb begin
        w_stk_op.pop  = 1'b0;
        w_stk_op.push = 1'b0;
        w_div_start   = 1'b0;
        w_load        = 1'b0;
        unique case (r_state)
            fbpa_pkg::S_IDLE: begin
                w_stk_op.pop  = w_acc && (i_req.action == fbpa_pkg::ACT_ALLOC)
                                && (w_count != '0);
                w_div_start   = w_acc && (i_req.action == fbpa_pkg::ACT_FREE)
                                && (i_req.address != '0) && (i_req.address >= r_base);
            end
            fbpa_pkg::S_DIV: begin
                w_stk_op.push = w_div.done && w_div_ok && (w_count < CNT_W'(CAPACITY));
            end
            fbpa_pkg::S_DONE: begin
                w_load = !r_rsp_valid || o_rsp.ready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (w_stk_op.pop) begin
                    n_state = fbpa_pkg::S_MUL;
                end else if (w_div_start) begin
                    n_state = fbpa_pkg::S_DIV;
                end else if (w_acc) begin
                    n_state = fbpa_pkg::S_DONE;
                end
            end
            fbpa_pkg::S_MUL: n_state = fbpa_pkg::S_ADD;
            fbpa_pkg::S_ADD: n_state = fbpa_pkg::S_DONE;
            fbpa_pkg::S_DIV: begin
                if (w_div.done) begin
                    n_state = fbpa_pkg::S_DONE;
                end
            end
            fbpa_pkg::S_DONE: begin
                if (w_load) begin
                    n_state = fbpa_pkg::S_IDLE;
                end
            end
            default: n_state = fbpa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_bsize <= fbpa_pkg::BSIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fbpa_pkg::CFG_BASE_ADDR:  r_base  <= i_cfg_data;
                fbpa_pkg::CFG_BLOCK_SIZE: r_bsize <= i_cfg_data[BSIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_high      <= '0;
            r_alloc_tot <= '0;
            r_free_tot  <= '0;
        end else if (r_state == fbpa_pkg::S_ADD) begin
            r_in_use <= w_in_use_inc;
            if (w_in_use_inc > r_high) begin
                r_high <= w_in_use_inc;
            end
            if (r_alloc_tot != '1) begin
                r_alloc_tot <= r_alloc_tot + 1'b1;
            end
        end else if (w_stk_op.push) begin
            if (r_in_use != '0) begin
                r_in_use <= r_in_use - 1'b1;
            end
            if (r_free_tot != '1) begin
                r_free_tot <= r_free_tot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res_addr <= '0;
            if (i_req.action == fbpa_pkg::ACT_ALLOC) begin
                r_status <= fbpa_pkg::ST_EMPTY;
            end else if (i_req.address == '0) begin
                r_status <= fbpa_pkg::ST_NULL;
            end else begin
                r_status <= fbpa_pkg::ST_INVALID;
            end
        end
        if (r_state == fbpa_pkg::S_MUL) begin
            r_prod <= PROD_W'(w_top) * PROD_W'(w_bs_eff);
        end
        if (r_state == fbpa_pkg::S_ADD) begin
            r_res_addr <= r_base + ADDR_W'(r_prod);
            r_status   <= fbpa_pkg::ST_OK;
        end
        if ((r_state == fbpa_pkg::S_DIV) && w_div.done && w_div_ok) begin
            r_status <= (w_count < CNT_W'(CAPACITY)) ? fbpa_pkg::ST_OK : fbpa_pkg::ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_load) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rsp_status  <= r_status;
            r_rsp_addr    <= r_res_addr;
            r_rsp_in_use  <= r_in_use;
            r_rsp_high    <= r_high;
            r_rsp_alloc   <= r_alloc_tot;
            r_rsp_free    <= r_free_tot;
        end
    end

    assign i_req.ready           = w_ready;
    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.status          = r_rsp_status;
    assign o_rsp.block_address   = r_rsp_addr;
    assign o_rsp.in_use          = r_rsp_in_use;
    assign o_rsp.highest_in_use  = r_rsp_high;
    assign o_rsp.total_allocated = r_rsp_alloc;
    assign o_rsp.total_freed     = r_rsp_free;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(CAPACITY))
        else $error("free stack depth above capacity");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_in_use} + {1'b0, w_count}) <= (CNT_W + 1)'(CAPACITY))
        else $error("blocks in use plus free blocks exceed capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(w_count) |-> (w_count == $past(w_count) + 1'b1)
                           || (w_count == $past(w_count) - 1'b1))
        else $error("free stack depth moved by more than one");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == fbpa_pkg::S_DIV))
        else $error("divider finished outside a free");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_fixed_block_pool_allocator.sv =====
// Self-checking testbench of the fixed block pool allocator: directed cases, then random traffic.
`default_nettype none
module tb_fixed_block_pool_allocator;

    localparam int CAPACITY  = fbpa_pkg::CAPACITY;
    localparam int ADDR_W    = fbpa_pkg::ADDR_W;
    localparam int BSIZE_W   = fbpa_pkg::BSIZE_W;
    localparam int TOTAL_W   = fbpa_pkg::TOTAL_W;
    localparam int CFG_IDX_W = fbpa_pkg::CFG_IDX_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LIMIT = 400000;
    localparam int MAX_PRINT = 40;

    typedef struct {
        fbpa_pkg::t_status   status;
        logic [ADDR_W-1:0]   blk_addr;
        logic [CNT_W-1:0]    used;
        logic [CNT_W-1:0]    peak;
        logic [TOTAL_W-1:0]  n_alloc;
        logic [TOTAL_W-1:0]  n_freed;
    } t_pool_rsp;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ADDR_W-1:0]    i_cfg_data;

    fbpa_req_if req_if ();
    fbpa_rsp_if rsp_if ();

    fixed_block_pool_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the pool: free index stack, counters, registers
    logic [IDX_W-1:0]   spare_idx [CAPACITY];
    int unsigned        spare_cnt;
    logic [CNT_W-1:0]   used_cnt;
    logic [CNT_W-1:0]   peak_cnt;
    logic [TOTAL_W-1:0] alloc_cnt;
    logic [TOTAL_W-1:0] freed_cnt;
    logic [ADDR_W-1:0]  cfg_base;
    logic [BSIZE_W-1:0] cfg_bsize;

    t_pool_rsp         pending_rsp [$];
    int                held_idx [$];
    logic [ADDR_W-1:0] last_blk;
    logic              filling = 1'b1;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int cycle_cnt = 0;
    int n_err = 0;
    int n_req = 0;
    int n_rsp = 0;
    int n_cfg = 0;
    int status_seen [5];

    function automatic logic [ADDR_W-1:0] eff_bsize();
        return (cfg_bsize == '0) ? ADDR_W'(1) : ADDR_W'(cfg_bsize);
    endfunction

    function automatic logic [ADDR_W-1:0] block_at(input int idx);
        return ADDR_W'(64'(cfg_base) + 64'(idx) * 64'(eff_bsize()));
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic t_pool_rsp pool_predict(input logic act, input logic [ADDR_W-1:0] addr,
                                               output int popped);
        t_pool_rsp   r;
        logic [63:0] lo;
        logic [63:0] a64;
        logic [63:0] bs64;
        logic [63:0] span;
        lo   = 64'(cfg_base);
        a64  = 64'(addr);
        bs64 = 64'(eff_bsize());
        span = bs64 * 64'(CAPACITY);
        popped = -1;
        r.blk_addr = '0;
        if (act == fbpa_pkg::ACT_ALLOC) begin
            if (spare_cnt == 0) begin
                r.status = fbpa_pkg::ST_EMPTY;
            end else begin
                spare_cnt--;
                popped = int'(spare_idx[spare_cnt]);
                r.blk_addr = ADDR_W'(lo + 64'(popped) * bs64);
                used_cnt++;
                alloc_cnt = sat_inc(alloc_cnt);
                if (used_cnt > peak_cnt) peak_cnt = used_cnt;
                r.status = fbpa_pkg::ST_OK;
            end
        end else if (addr == '0) begin
            r.status = fbpa_pkg::ST_NULL;
        end else if (a64 < lo || (a64 - lo) >= span || ((a64 - lo) % bs64) != 0) begin
            r.status = fbpa_pkg::ST_INVALID;
        end else if (spare_cnt >= CAPACITY) begin
            r.status = fbpa_pkg::ST_FULL;
        end else begin
            spare_idx[spare_cnt] = IDX_W'((a64 - lo) / bs64);
            spare_cnt++;
            if (used_cnt > 0) used_cnt--;
            freed_cnt = sat_inc(freed_cnt);
            r.status = fbpa_pkg::ST_OK;
        end
        r.used    = used_cnt;
        r.peak    = peak_cnt;
        r.n_alloc = alloc_cnt;
        r.n_freed = freed_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (n_err < MAX_PRINT)
            $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
        n_err++;
    endtask

    task automatic send_req(input logic act, input logic [ADDR_W-1:0] addr);
        t_pool_rsp r;
        int        popped;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.action  <= act;
        req_if.address <= addr;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        r = pool_predict(act, addr, popped);
        pending_rsp.push_back(r);
        last_blk = r.blk_addr;
        if (popped >= 0) held_idx.push_back(popped);
        n_req++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        wait_drained();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == fbpa_pkg::CFG_BASE_ADDR) cfg_base = data;
        else cfg_bsize = data[BSIZE_W-1:0];
        n_cfg++;
    endtask

    // mostly frees of handed-out blocks, some double frees, the rest malformed addresses
    function automatic logic [ADDR_W-1:0] pick_free_addr();
        int                sel;
        int                k;
        int                idx;
        logic [ADDR_W-1:0] bs;
        bs  = eff_bsize();
        sel = $urandom_range(99);
        if (sel < 75 && held_idx.size() > 0) begin
            k = $urandom_range(held_idx.size() - 1);
            idx = held_idx[k];
            held_idx.delete(k);
            return block_at(idx);
        end
        if (sel < 85) return block_at($urandom_range(CAPACITY - 1));
        case (sel % 5)
            0: return '0;
            1: return (bs > 1) ? block_at($urandom_range(CAPACITY - 1)) + $urandom_range(bs - 1, 1)
                               : ADDR_W'($urandom());
            2: return (cfg_base > 0) ? ADDR_W'($urandom_range(cfg_base - 1, 0))
                                     : ADDR_W'($urandom());
            3: return block_at(CAPACITY) + $urandom_range(4 * bs);
            default: return ADDR_W'($urandom());
        endcase
    endfunction

    task automatic test_reset_state();
        logic [ADDR_W-1:0] blk;
        send_req(fbpa_pkg::ACT_ALLOC, '0);
        blk = last_blk;
        send_req(fbpa_pkg::ACT_FREE, '0);
        send_req(fbpa_pkg::ACT_FREE, '1);
        send_req(fbpa_pkg::ACT_FREE, ADDR_W'(65));
        send_req(fbpa_pkg::ACT_FREE, blk);
        send_req(fbpa_pkg::ACT_FREE, ADDR_W'(64));
        send_req(fbpa_pkg::ACT_ALLOC, '1);
    endtask

    task automatic test_top_of_space();
        logic [ADDR_W-1:0] blk;
        cfg_write(fbpa_pkg::CFG_BASE_ADDR, 32'hFFFF_F000);
        cfg_write(fbpa_pkg::CFG_BLOCK_SIZE, ADDR_W'(17'h1_0000));
        send_req(fbpa_pkg::ACT_ALLOC, '0);
        blk = last_blk;
        send_req(fbpa_pkg::ACT_FREE, blk);
        send_req(fbpa_pkg::ACT_FREE, 32'hFFFF_EFFF);
        send_req(fbpa_pkg::ACT_FREE, 32'hFFFF_F000);
        send_req(fbpa_pkg::ACT_FREE, 32'hFFFF_F000);
        send_req(fbpa_pkg::ACT_FREE, 32'hFFFF_F000);
        send_req(fbpa_pkg::ACT_ALLOC, '0);
    endtask

    task automatic test_zero_block_size();
        cfg_write(fbpa_pkg::CFG_BLOCK_SIZE, 32'hFFFE_0000);
        cfg_write(fbpa_pkg::CFG_BASE_ADDR, 32'h0000_0100);
        send_req(fbpa_pkg::ACT_ALLOC, '0);
        send_req(fbpa_pkg::ACT_FREE, 32'h0000_01FF);
        send_req(fbpa_pkg::ACT_FREE, 32'h0000_0200);
        send_req(fbpa_pkg::ACT_FREE, 32'h0000_00FF);
        send_req(fbpa_pkg::ACT_ALLOC, '0);
    endtask

    task automatic test_traffic(input int send_pct, input int stall_pct,
                                input logic [ADDR_W-1:0] base, input logic [BSIZE_W-1:0] bsize,
                                input int n_items);
        int   i;
        logic alloc;
        cfg_write(fbpa_pkg::CFG_BASE_ADDR, base);
        cfg_write(fbpa_pkg::CFG_BLOCK_SIZE, ADDR_W'(bsize));
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(63) == 0) wait_drained();
            if (filling && spare_cnt == 0 && $urandom_range(3) == 0) filling = 1'b0;
            else if (!filling && spare_cnt == CAPACITY && $urandom_range(3) == 0) filling = 1'b1;
            alloc = filling ? ($urandom_range(99) < 90) : ($urandom_range(99) < 10);
            if (alloc) send_req(fbpa_pkg::ACT_ALLOC, ADDR_W'($urandom()));
            else send_req(fbpa_pkg::ACT_FREE, pick_free_addr());
        end
    endtask

    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge i_clk) begin
        t_pool_rsp e;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            n_rsp++;
            case (rsp_if.status)
                fbpa_pkg::ST_OK:      status_seen[0]++;
                fbpa_pkg::ST_EMPTY:   status_seen[1]++;
                fbpa_pkg::ST_NULL:    status_seen[2]++;
                fbpa_pkg::ST_INVALID: status_seen[3]++;
                fbpa_pkg::ST_FULL:    status_seen[4]++;
                default:    ;
            endcase
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected beat", 64'(rsp_if.status), 0);
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_if.status !== e.status)
                    report_mismatch("status", 64'(rsp_if.status), 64'(e.status));
                if (rsp_if.block_address !== e.blk_addr)
                    report_mismatch("block_address", 64'(rsp_if.block_address), 64'(e.blk_addr));
                if (rsp_if.in_use !== e.used)
                    report_mismatch("in_use", 64'(rsp_if.in_use), 64'(e.used));
                if (rsp_if.highest_in_use !== e.peak)
                    report_mismatch("highest_in_use", 64'(rsp_if.highest_in_use), 64'(e.peak));
                if (rsp_if.total_allocated !== e.n_alloc)
                    report_mismatch("total_allocated", 64'(rsp_if.total_allocated),
                                    64'(e.n_alloc));
                if (rsp_if.total_freed !== e.n_freed)
                    report_mismatch("total_freed", 64'(rsp_if.total_freed), 64'(e.n_freed));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int i;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = fbpa_pkg::CFG_BASE_ADDR;
        i_cfg_data     = '0;
        req_if.valid   = 1'b0;
        req_if.action  = fbpa_pkg::ACT_ALLOC;
        req_if.address = '0;
        rsp_if.ready   = 1'b0;
        for (i = 0; i < CAPACITY; i++) spare_idx[i] = IDX_W'(i);
        for (i = 0; i < 5; i++) status_seen[i] = 0;
        spare_cnt = CAPACITY;
        used_cnt  = '0;
        peak_cnt  = '0;
        alloc_cnt = '0;
        freed_cnt = '0;
        cfg_base  = '0;
        cfg_bsize = fbpa_pkg::BSIZE_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_top_of_space();
        test_zero_block_size();
        test_traffic(0, 0, 32'h0010_0000, BSIZE_W'(48), 258);
        test_traffic(52, 0, 32'h0000_0000, BSIZE_W'(17'h1_0000), 258);
        test_traffic(0, 52, ADDR_W'($urandom()) & 32'h7FFF_FFF0, BSIZE_W'(1), 258);
        test_traffic(35, 35, ADDR_W'($urandom_range(32'hFF00_0000, 32'h0100_0000)),
                     BSIZE_W'($urandom_range(4096, 2)), 258);

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d requests, %0d responses, %0d register writes, four idle mixes.",
                 n_req, n_rsp, n_cfg);
        $display("Responses: ok %0d, empty %0d, null %0d, bad address %0d, list full %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (n_err == 0 && pending_rsp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
